@@ rtl/pulse_interval_nibble_decoder_top_assert.svh @@
// Assertion macros for the pulse interval nibble decoder.
`ifndef PULSE_INTERVAL_NIBBLE_DECODER_TOP_ASSERT_SVH
`define PULSE_INTERVAL_NIBBLE_DECODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property on clk, disabled while rst_n is low
`define PIND_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on clk at every edge, reset included
`define PIND_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIND_ASSERT(label, prop, msg)
`define PIND_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ rtl/pind_pkg.sv @@
// Shared types and constants of the pulse interval nibble decoder.
package pind_pkg;

    localparam int unsigned NIB_W   = 4;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CFG_W   = 16;

    localparam logic [15:0] TIMEOUT_RST   = 16'd3000;
    localparam logic [7:0]  OFFSET_RST    = 8'd10;
    localparam logic [15:0] THRESHOLD_RST = 16'd992;
    localparam logic [7:0]  BIN_WIDTH_RST = 8'd64;

    localparam logic [TICK_W-1:0] TICK_MAX  = '1;
    localparam logic [BYTE_W-1:0] COUNT_MAX = '1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TIMEOUT_PERIOD = 2'd0,
        REG_CAPTURE_OFFSET = 2'd1,
        REG_BASE_THRESHOLD = 2'd2,
        REG_BIN_WIDTH      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [15:0] timeout_period;
        logic [7:0]  capture_offset;
        logic [15:0] base_threshold;
        logic [7:0]  bin_width;
    } cfg_t;

    // Frame tracker status seen by the top level
    typedef struct packed {
        logic running;
        logic nibble_pending;
    } frame_status_t;

endpackage

@@ rtl/pind_cfg_regs.sv @@
// Configuration register file of the pulse interval nibble decoder.
module pind_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [15:0]         wr_data,
    output pind_pkg::cfg_t      cfg
);
    import pind_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index into one register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index_t'(wr_index))
                REG_TIMEOUT_PERIOD: cfg_next.timeout_period = wr_data;
                REG_CAPTURE_OFFSET: cfg_next.capture_offset = wr_data[7:0];
                REG_BASE_THRESHOLD: cfg_next.base_threshold = wr_data;
                REG_BIN_WIDTH:      cfg_next.bin_width      = wr_data[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_period <= TIMEOUT_RST;
            cfg_reg.capture_offset <= OFFSET_RST;
            cfg_reg.base_threshold <= THRESHOLD_RST;
            cfg_reg.bin_width      <= BIN_WIDTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pind_quant.sv @@
// Interval quantizer: parallel compare against the bin edges.
module pind_quant #(
    parameter int unsigned NUM_BINS = 16
) (
    input  logic [15:0]         elapsed,
    input  pind_pkg::cfg_t      cfg,
    output logic [3:0]          nibble
);
    import pind_pkg::*;

    localparam int unsigned CAP_W = TICK_W + 1;

    logic [CAP_W-1:0] capture;
    logic [CAP_W-1:0] diff;
    logic [CAP_W-1:0] width_ext;
    logic [CAP_W-1:0] last_edge;
    logic             above;
    logic             beyond;
    logic [NIB_W-1:0] bin;

    // Add the offset and measure the distance above the threshold
    assign capture   = {1'b0, elapsed} + {{(CAP_W-8){1'b0}}, cfg.capture_offset};
    assign above     = capture > {1'b0, cfg.base_threshold};
    assign diff      = capture - {1'b0, cfg.base_threshold};
    assign width_ext = {{(CAP_W-8){1'b0}}, cfg.bin_width};
    assign last_edge = CAP_W'(NUM_BINS) * width_ext;
    assign beyond    = diff >= last_edge;

    // Pick the highest bin edge that the distance reaches
    always_comb
    begin
        bin = '0;
        for (int k = 1; k < NUM_BINS; k++)
        begin
            if (diff >= CAP_W'(k) * width_ext)
            begin
                bin = NIB_W'(k);
            end
        end
    end

    assign nibble = (above && (cfg.bin_width != 8'd0) && !beyond) ? bin : '0;

endmodule

@@ rtl/pind_frame.sv @@
// Frame tracker: interval counter, nibble pairing and the result register.
module pind_frame #(
    parameter int unsigned NUM_BINS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pind_pkg::cfg_t          cfg,
    input  logic                    item_valid,
    input  logic                    item_edge,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              data_byte,
    output logic                    byte_valid,
    output logic                    frame_end,
    output logic [7:0]              frame_bytes,
    output pind_pkg::frame_status_t status
);
    import pind_pkg::*;

    logic              running_reg, running_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [NIB_W-1:0]  low_nib_reg, low_nib_next;
    logic              pending_reg, pending_next;
    logic [BYTE_W-1:0] bytes_reg, bytes_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic              byte_valid_reg, byte_valid_next;
    logic              frame_end_reg, frame_end_next;
    logic [BYTE_W-1:0] count_reg, count_next;

    logic [TICK_W-1:0] elapsed;
    logic [NIB_W-1:0]  nibble;
    logic              emit;

    // Advance when the result register is free or being drained
    assign take = item_valid && (!out_valid_reg || out_ready);

    assign elapsed = (tick_reg == TICK_MAX) ? TICK_MAX : tick_reg + 16'd1;

    pind_quant #(
        .NUM_BINS (NUM_BINS)
    ) u_quant (
        .elapsed (elapsed),
        .cfg     (cfg),
        .nibble  (nibble)
    );

    // Next frame state and the result of this tick
    always_comb
    begin
        running_next    = running_reg;
        tick_next       = tick_reg;
        low_nib_next    = low_nib_reg;
        pending_next    = pending_reg;
        bytes_next      = bytes_reg;
        emit            = 1'b0;
        data_next       = data_reg;
        byte_valid_next = byte_valid_reg;
        frame_end_next  = frame_end_reg;
        count_next      = count_reg;
        if (take)
        begin
            if (!running_reg)
            begin
                if (item_edge)
                begin
                    running_next = 1'b1;
                    tick_next    = '0;
                end
            end
            else if (item_edge)
            begin
                tick_next = '0;
                if (!pending_reg)
                begin
                    low_nib_next = nibble;
                    pending_next = 1'b1;
                end
                else
                begin
                    pending_next    = 1'b0;
                    low_nib_next    = '0;
                    bytes_next      = (bytes_reg == COUNT_MAX) ? bytes_reg
                                                               : bytes_reg + 8'd1;
                    emit            = 1'b1;
                    data_next       = {nibble, low_nib_reg};
                    byte_valid_next = 1'b1;
                    frame_end_next  = 1'b0;
                    count_next      = '0;
                end
            end
            else
            begin
                tick_next = elapsed;
                if (elapsed >= cfg.timeout_period)
                begin
                    emit            = 1'b1;
                    data_next       = '0;
                    byte_valid_next = 1'b0;
                    frame_end_next  = 1'b1;
                    count_next      = bytes_reg;
                    // Drop any odd nibble and go idle
                    running_next    = 1'b0;
                    tick_next       = '0;
                    low_nib_next    = '0;
                    pending_next    = 1'b0;
                    bytes_next      = '0;
                end
            end
        end
    end

    // Hold the result until the downstream side takes it
    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            tick_reg      <= '0;
            low_nib_reg   <= '0;
            pending_reg   <= 1'b0;
            bytes_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg   <= running_next;
            tick_reg      <= tick_next;
            low_nib_reg   <= low_nib_next;
            pending_reg   <= pending_next;
            bytes_reg     <= bytes_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload carries no reset
    always_ff @(posedge clk)
    begin
        data_reg       <= data_next;
        byte_valid_reg <= byte_valid_next;
        frame_end_reg  <= frame_end_next;
        count_reg      <= count_next;
    end

    assign out_valid             = out_valid_reg;
    assign data_byte             = data_reg;
    assign byte_valid            = byte_valid_reg;
    assign frame_end             = frame_end_reg;
    assign frame_bytes           = count_reg;
    assign status.running        = running_reg;
    assign status.nibble_pending = pending_reg;

endmodule

@@ rtl/pulse_interval_nibble_decoder_top.sv @@
// An accepted tick is held in the input register; the frame tracker takes it
// and loads its result into the result register once that register is free or draining.
// Throughput: one tick per cycle; the input register refills while the result
// register drains, so the only stall is a result left waiting on out_ready.
// Each tick is handled in one pass of the frame tracker and bin comparators.
// Reset: rst_n clears the frame state and both valid flags and loads the
// register defaults (timeout 3000, offset 10, threshold 992, bin width 64).
`include "pulse_interval_nibble_decoder_top_assert.svh"

// Top level of the pulse interval nibble decoder.
module pulse_interval_nibble_decoder_top #(
    parameter int unsigned NUM_BINS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        edge_seen,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        byte_valid,
    output logic        frame_end,
    output logic [7:0]  frame_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pind_pkg::*;

    cfg_t          cfg;
    frame_status_t status;
    logic          take;
    logic          item_valid_reg, item_valid_next;
    logic          item_edge_reg;

    assign cfg_ready = 1'b1;

    pind_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Accept a tick whenever the input register is empty or moving on
    assign in_ready        = !item_valid_reg || take;
    assign item_valid_next = (in_valid && in_ready) || (item_valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_edge_reg <= edge_seen;
        end
    end

    pind_frame #(
        .NUM_BINS (NUM_BINS)
    ) u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .item_valid  (item_valid_reg),
        .item_edge   (item_edge_reg),
        .take        (take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .frame_end   (frame_end),
        .frame_bytes (frame_bytes),
        .status      (status)
    );

    // A result is either a byte or a frame end, never both
    `PIND_ASSERT(a_result_kind, out_valid |-> (byte_valid != frame_end), "result kind not unique")
    // An idle tracker holds no half byte
    `PIND_ASSERT_ALWAYS(a_idle_no_nibble, !status.running |-> !status.nibble_pending, "nibble left while idle")
    // A buffered tick is kept until the tracker takes it
    `PIND_ASSERT(a_item_kept, (item_valid_reg && !take) |=> item_valid_reg, "buffered tick lost")
    // A frame end leaves the tracker idle
    `PIND_ASSERT(a_end_idle, (out_valid && frame_end && !$stable(frame_end)) |-> !status.running, "running after frame end")

endmodule
